@@ design/epdrp_pkg.sv @@
// Shared types, constants and the color classifier for the e-paper rotate and pack block.
// No dependencies; used by epdrp_store.sv and rgb565_epd_rotate_pack.sv.

package epdrp_pkg;

  // Request types carried on the req_type field.
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  // Configuration register indexes.
  localparam int CFG_INDEX_W = 4;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_BLACK  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_WHITE  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_YELLOW = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_CODE_RED    = 4'd3;

  // Channel thresholds of the color sort.
  localparam logic [4:0] RED_HIGH_MIN   = 5'd20;  // red channel strictly above
  localparam logic [5:0] RED_GREEN_MAX  = 6'd12;  // green strictly below, red pixel
  localparam logic [4:0] RED_BLUE_MAX   = 5'd12;  // blue strictly below, red pixel
  localparam logic [5:0] YEL_GREEN_MIN  = 6'd40;  // green strictly above, yellow pixel
  localparam logic [4:0] YEL_BLUE_MAX   = 5'd8;
  localparam logic [4:0] BLK_RED_MAX    = 5'd8;
  localparam logic [5:0] BLK_GREEN_MAX  = 6'd10;
  localparam logic [4:0] BLK_BLUE_MAX   = 5'd8;

  // Depth of the result queue and its pointer width.
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  typedef enum logic [1:0] {
    COLOR_RED,
    COLOR_YELLOW,
    COLOR_BLACK,
    COLOR_WHITE
  } color_t;

  // Control of one store access; the address travels beside it.
  typedef struct packed {
    logic       wr_en;
    logic       rd_en;
    logic [1:0] lane;   // two-bit lane, 3 is the high bits of the byte
    logic [1:0] code;
  } store_ctl_t;

  // Tests run in priority order: red, yellow, black, then white.
  function automatic color_t classify(input logic [4:0] r, input logic [5:0] g,
                                      input logic [4:0] b);
    color_t c;
    if (r > RED_HIGH_MIN && g < RED_GREEN_MAX && b < RED_BLUE_MAX) begin
      c = COLOR_RED;
    end else if (r > RED_HIGH_MIN && g > YEL_GREEN_MIN && b < YEL_BLUE_MAX) begin
      c = COLOR_YELLOW;
    end else if (r < BLK_RED_MAX && g < BLK_GREEN_MAX && b < BLK_BLUE_MAX) begin
      c = COLOR_BLACK;
    end else begin
      c = COLOR_WHITE;
    end
    return c;
  endfunction

endpackage

@@ design/epdrp_store.sv @@
// Packed portrait pixel store: single-port synchronous RAM with two-bit lane writes.
// Depends on epdrp_pkg for the access control struct.

module epdrp_store #(
  parameter int DEPTH  = 9472,
  parameter int ADDR_W = 14
) (
  input  logic                  clk,
  input  epdrp_pkg::store_ctl_t ctl,
  input  logic [ADDR_W-1:0]     addr,
  output logic [7:0]            rd_data
);

  logic [7:0] mem [DEPTH];

  // A lane write touches only its own two bits, so no read-modify-write is needed.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr][{ctl.lane, 1'b0} +: 2] <= ctl.code;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

@@ design/rgb565_epd_rotate_pack.sv @@
// Top level of the e-paper rotate and pack block: request decode, pipeline and result queue.
// Depends on epdrp_pkg and epdrp_store.

// This block takes one request beat per cycle. A write beat carries an RGB565
// pixel of a landscape frame (FRAME_WIDTH columns by FRAME_HEIGHT rows) with its
// column and row; the pixel is sorted into red, yellow, black or white, and the
// matching two-bit code from the configuration registers is written into a
// portrait store rotated by 90 degrees, four pixels per byte with the first pixel
// in the high bits. Writes outside the frame are dropped and return nothing. A
// read beat puts the packed byte at read_index into the result queue, or zero for
// an index past the end of the store. Requests are taken back to back at one per
// cycle while in_ready is high; the rate is set by the single port of the store,
// which serves one write or one read each cycle. Pixel writes update their lane
// directly in the RAM, so a read that follows a write to the same byte always
// sees it. The store has no reset: a byte must have all four pixels written
// before it is read. Results wait in a four-beat queue, and in_ready drops only
// when reads in flight plus queued results would overflow it. Configuration
// writes are always accepted and should be made while no request is in flight.

module rgb565_epd_rotate_pack #(
  parameter int FRAME_WIDTH  = 296,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [8:0]                        column,
  input  logic [6:0]                        row,
  input  logic [4:0]                        red,
  input  logic [5:0]                        green,
  input  logic [4:0]                        blue,
  input  logic [13:0]                       read_index,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [7:0]                        read_data,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [epdrp_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [1:0]                        cfg_data
);

  localparam int ROW_BYTES   = (FRAME_HEIGHT + 3) / 4;
  localparam int STORE_BYTES = FRAME_WIDTH * ROW_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  // One spare bit keeps the byte part of the portrait x at least one bit wide.
  localparam int PX_W        = $clog2(FRAME_HEIGHT) + 1;

  // Configuration registers.
  logic [1:0] code_black;
  logic [1:0] code_white;
  logic [1:0] code_yellow;
  logic [1:0] code_red;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      code_black  <= 2'd0;
      code_white  <= 2'd1;
      code_yellow <= 2'd2;
      code_red    <= 2'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        epdrp_pkg::CFG_CODE_BLACK:  code_black  <= cfg_data;
        epdrp_pkg::CFG_CODE_WHITE:  code_white  <= cfg_data;
        epdrp_pkg::CFG_CODE_YELLOW: code_yellow <= cfg_data;
        epdrp_pkg::CFG_CODE_RED:    code_red    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request decode. The portrait x is the mirrored landscape row and the
  // portrait y is the column; x/4 picks the byte and x%4 the pixel within it.
  logic                 in_fire;
  logic                 pix_in_frame;
  logic                 idx_in_store;
  logic [PX_W-1:0]      px;
  logic [ADDR_W-1:0]    wr_addr;
  logic [ADDR_W-1:0]    req_addr;
  epdrp_pkg::color_t    color;
  logic [1:0]           pix_code;

  assign in_fire      = in_valid && in_ready;
  assign pix_in_frame = (32'(column) < FRAME_WIDTH) && (32'(row) < FRAME_HEIGHT);
  assign idx_in_store = 32'(read_index) < STORE_BYTES;
  assign px           = PX_W'(FRAME_HEIGHT - 1) - PX_W'(row);
  assign wr_addr      = ADDR_W'(ADDR_W'(column) * ADDR_W'(ROW_BYTES))
                      + ADDR_W'(px[PX_W-1:2]);
  assign req_addr     = (req_type == epdrp_pkg::REQ_READ) ? ADDR_W'(read_index) : wr_addr;
  assign color        = epdrp_pkg::classify(red, green, blue);

  always_comb begin
    case (color)
      epdrp_pkg::COLOR_RED:    pix_code = code_red;
      epdrp_pkg::COLOR_YELLOW: pix_code = code_yellow;
      epdrp_pkg::COLOR_BLACK:  pix_code = code_black;
      default:                 pix_code = code_white;
    endcase
  end

  // Stage 1: decoded request, presented to the store in the next cycle.
  logic              s1_valid;
  logic              s1_read;
  logic              s1_ok;
  logic [ADDR_W-1:0] s1_addr;
  logic [1:0]        s1_lane;
  logic [1:0]        s1_code;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_fire;
    end
    if (in_fire) begin
      s1_read <= (req_type == epdrp_pkg::REQ_READ);
      s1_ok   <= (req_type == epdrp_pkg::REQ_READ) ? idx_in_store : pix_in_frame;
      s1_addr <= req_addr;
      s1_lane <= ~px[1:0];
      s1_code <= pix_code;
    end
  end

  epdrp_pkg::store_ctl_t store_ctl;
  logic [7:0]            store_rd_data;

  always_comb begin
    store_ctl.wr_en = s1_valid && !s1_read && s1_ok;
    store_ctl.rd_en = s1_valid && s1_read && s1_ok;
    store_ctl.lane  = s1_lane;
    store_ctl.code  = s1_code;
  end

  epdrp_store #(
    .DEPTH  (STORE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .ctl     (store_ctl),
    .addr    (s1_addr),
    .rd_data (store_rd_data)
  );

  // Stage 2: read data is out of the RAM; an index past the store reads as zero.
  logic s2_valid;
  logic s2_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_read;
    end
    if (s1_valid && s1_read) begin
      s2_ok <= s1_ok;
    end
  end

  // Result queue. Reads in flight have a reserved slot, so a push never finds it full.
  logic [7:0]                      q_data [epdrp_pkg::OUT_DEPTH];
  logic [epdrp_pkg::OUT_PTR_W-1:0] q_wr_ptr;
  logic [epdrp_pkg::OUT_PTR_W-1:0] q_rd_ptr;
  logic [epdrp_pkg::OUT_CNT_W-1:0] q_count;
  logic [epdrp_pkg::OUT_CNT_W-1:0] q_count_next;
  logic [epdrp_pkg::OUT_CNT_W-1:0] pending;
  logic                            q_push;
  logic                            q_pop;

  assign q_push    = s2_valid;
  assign q_pop     = out_valid && out_ready;
  assign out_valid = (q_count != '0);
  assign read_data = q_data[q_rd_ptr];

  assign pending = q_count
                 + epdrp_pkg::OUT_CNT_W'(s2_valid)
                 + epdrp_pkg::OUT_CNT_W'(s1_valid && s1_read);
  assign in_ready = pending < epdrp_pkg::OUT_CNT_W'(epdrp_pkg::OUT_DEPTH);

  always_comb begin
    q_count_next = q_count;
    if (q_push && !q_pop) begin
      q_count_next = q_count + 1'b1;
    end else if (q_pop && !q_push) begin
      q_count_next = q_count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wr_ptr <= '0;
      q_rd_ptr <= '0;
      q_count  <= '0;
    end else begin
      q_count <= q_count_next;
      if (q_push) begin
        q_wr_ptr <= q_wr_ptr + 1'b1;
      end
      if (q_pop) begin
        q_rd_ptr <= q_rd_ptr + 1'b1;
      end
    end
    if (q_push) begin
      q_data[q_wr_ptr] <= s2_ok ? store_rd_data : 8'd0;
    end
  end

endmodule

@@ tb/epd_pack_checker.sv @@
// Checker for the e-paper rotate and pack block: watches the request, result and
// configuration channels, keeps a shadow of the portrait store and compares read beats.
// Depends on epdrp_pkg for the request types, register indexes and color enum.

module epd_pack_checker
  import epdrp_pkg::*;
#(
  parameter int FRAME_WIDTH  = 296,
  parameter int FRAME_HEIGHT = 128
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   req_type,
  input  logic [8:0]             column,
  input  logic [6:0]             row,
  input  logic [4:0]             red,
  input  logic [5:0]             green,
  input  logic [4:0]             blue,
  input  logic [13:0]            read_index,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [7:0]             read_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [1:0]             cfg_data,
  output int                     bytes_due_count,
  output int                     mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_BYTES   = (FRAME_HEIGHT + 3) / 4;
  localparam int STORE_BYTES = FRAME_WIDTH * ROW_BYTES;

  // Channel limits of the color sort, all strict comparisons.
  localparam int RED_FLOOR        = 20;
  localparam int RED_GREEN_CAP    = 12;
  localparam int RED_BLUE_CAP     = 12;
  localparam int YELLOW_GREEN_MIN = 40;
  localparam int YELLOW_BLUE_CAP  = 8;
  localparam int BLACK_RED_CAP    = 8;
  localparam int BLACK_GREEN_CAP  = 10;
  localparam int BLACK_BLUE_CAP   = 8;

  logic [7:0] shadow_frame [STORE_BYTES];
  logic [1:0] panel_code [4];
  logic [7:0] bytes_due [$];

  function automatic color_t sort_pixel(input int r, input int g, input int b);
    if (r > RED_FLOOR && g < RED_GREEN_CAP && b < RED_BLUE_CAP) begin
      return COLOR_RED;
    end
    if (r > RED_FLOOR && g > YELLOW_GREEN_MIN && b < YELLOW_BLUE_CAP) begin
      return COLOR_YELLOW;
    end
    if (r < BLACK_RED_CAP && g < BLACK_GREEN_CAP && b < BLACK_BLUE_CAP) begin
      return COLOR_BLACK;
    end
    return COLOR_WHITE;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("epd_pack_checker: %0t ns: %s", $realtime, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    int         x;
    int         byte_at;
    int         shift;
    logic [7:0] want;
    color_t     color;
    if (rst) begin
      bytes_due.delete();
      panel_code[COLOR_BLACK]  = 2'd0;
      panel_code[COLOR_WHITE]  = 2'd1;
      panel_code[COLOR_YELLOW] = 2'd2;
      panel_code[COLOR_RED]    = 2'd3;
    end else begin
      // Results are taken first so a beat can never match a read accepted in the same cycle.
      if (out_valid && out_ready) begin
        if (bytes_due.size() == 0) begin
          report_mismatch($sformatf("result beat %02h with no read outstanding", read_data));
        end else begin
          want = bytes_due.pop_front();
          if (read_data !== want) begin
            report_mismatch($sformatf("read_data %02h, expected %02h", read_data, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (req_type == REQ_READ) begin
          bytes_due.push_back((read_index < STORE_BYTES) ? shadow_frame[read_index] : 8'h00);
        end else if (column < FRAME_WIDTH && row < FRAME_HEIGHT) begin
          x       = FRAME_HEIGHT - 1 - row;
          byte_at = column * ROW_BYTES + x / 4;
          shift   = (3 - x % 4) * 2;
          color   = sort_pixel(red, green, blue);
          shadow_frame[byte_at] = (shadow_frame[byte_at] & ~(8'h03 << shift))
                                | (8'(panel_code[color]) << shift);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_CODE_BLACK:  panel_code[COLOR_BLACK]  = cfg_data;
          CFG_CODE_WHITE:  panel_code[COLOR_WHITE]  = cfg_data;
          CFG_CODE_YELLOW: panel_code[COLOR_YELLOW] = cfg_data;
          CFG_CODE_RED:    panel_code[COLOR_RED]    = cfg_data;
          default: ;
        endcase
      end
    end
    bytes_due_count = bytes_due.size();
  end

endmodule

@@ tb/rgb565_epd_rotate_pack_tb.sv @@
// Top of the testbench for rgb565_epd_rotate_pack: clock, reset, request and result
// traffic, configuration writes and the verdict. Needs epdrp_pkg, the block and epd_pack_checker.

module rgb565_epd_rotate_pack_tb
  import epdrp_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_WIDTH  = 296;
  localparam int FRAME_HEIGHT = 128;
  localparam int ROW_BYTES    = (FRAME_HEIGHT + 3) / 4;
  localparam int STORE_BYTES  = FRAME_WIDTH * ROW_BYTES;
  localparam int INDEX_TOP    = (1 << 14) - 1;

  // The block offers a read result once it has gone through the store and the result queue;
  // writes end in the store, so the DRAIN_CYCLES quiet spell is plenty before a register write.
  localparam int DRAIN_CYCLES     = 8;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam int CYCLE_LIMIT      = 200_000;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic                   req_type;
  logic [8:0]             column;
  logic [6:0]             row;
  logic [4:0]             red;
  logic [5:0]             green;
  logic [4:0]             blue;
  logic [13:0]            read_index;
  logic                   out_valid;
  logic                   out_ready;
  logic [7:0]             read_data;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [1:0]             cfg_data;

  int bytes_due_count;
  int mismatches;
  int cycle_count;

  // Percent of cycles in which the sender idles and the receiver stalls.
  int gap_pct;
  int stall_pct;
  // The receiver serves one long hold-off for every request raised by the stimulus.
  int hold_asks;
  int hold_done;
  // Request beats that do something in the block; out-of-frame writes are not counted.
  int items_sent;

  // Which two-bit slots of each packed byte have been written. Only bytes whose four
  // slots are all written may ever be read back.
  logic [3:0] lanes_written [STORE_BYTES];
  int         full_bytes [$];

  rgb565_epd_rotate_pack #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .req_type  (req_type),
    .column    (column),
    .row       (row),
    .red       (red),
    .green     (green),
    .blue      (blue),
    .read_index(read_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  epd_pack_checker #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT)
  ) u_checker (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .req_type       (req_type),
    .column         (column),
    .row            (row),
    .red            (red),
    .green          (green),
    .blue           (blue),
    .read_index     (read_index),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .read_data      (read_data),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .bytes_due_count(bytes_due_count),
    .mismatches     (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Every task below is entered and left just after a falling edge, which is where all
  // inputs of the block change. The handshakes are looked at on the rising edge.

  // Offers one request beat and holds it until the block takes it. A random number of
  // idle cycles may come first, as the current sender idling asks.
  task automatic offer_request(input logic kind, input logic [8:0] col, input logic [6:0] rw,
                               input logic [4:0] r, input logic [5:0] g, input logic [4:0] b,
                               input logic [13:0] idx);
    while ($urandom_range(99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid   = 1'b1;
    req_type   = kind;
    column     = col;
    row        = rw;
    red        = r;
    green      = g;
    blue       = b;
    read_index = idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Picks a pixel that is half the time red, yellow or black, sometimes right at a threshold,
  // and sometimes anything at all.
  task automatic pick_color(output logic [4:0] r, output logic [5:0] g, output logic [4:0] b);
    logic [4:0] red_edges   [4] = '{5'd7, 5'd8, 5'd20, 5'd21};
    logic [5:0] green_edges [6] = '{6'd9, 6'd10, 6'd11, 6'd12, 6'd40, 6'd41};
    logic [4:0] blue_edges  [4] = '{5'd7, 5'd8, 5'd11, 5'd12};
    case ($urandom_range(5))
      0: begin
        r = 5'($urandom_range(31, 21));
        g = 6'($urandom_range(11));
        b = 5'($urandom_range(11));
      end
      1: begin
        r = 5'($urandom_range(31, 21));
        g = 6'($urandom_range(63, 41));
        b = 5'($urandom_range(7));
      end
      2: begin
        r = 5'($urandom_range(7));
        g = 6'($urandom_range(9));
        b = 5'($urandom_range(7));
      end
      3: begin
        r = red_edges[$urandom_range(3)];
        g = green_edges[$urandom_range(5)];
        b = blue_edges[$urandom_range(3)];
      end
      default: begin
        r = 5'($urandom);
        g = 6'($urandom);
        b = 5'($urandom);
      end
    endcase
  endtask

  // Writes one pixel given by its packed byte and its slot in that byte (slot 0 sits in
  // the high bits). The landscape column and row follow from the rotation.
  task automatic put_pixel(input int byte_idx, input int lane, input logic [4:0] r,
                           input logic [5:0] g, input logic [4:0] b);
    int x;
    x = (byte_idx % ROW_BYTES) * 4 + lane;
    offer_request(REQ_WRITE, 9'(byte_idx / ROW_BYTES), 7'(FRAME_HEIGHT - 1 - x), r, g, b,
                  14'($urandom));
    if (lanes_written[byte_idx] != 4'hF) begin
      lanes_written[byte_idx][lane] = 1'b1;
      if (lanes_written[byte_idx] == 4'hF) begin
        full_bytes.push_back(byte_idx);
      end
    end
    items_sent++;
  endtask

  // A read beat carries junk in the pixel fields, which the block must ignore.
  task automatic put_read(input int idx);
    offer_request(REQ_READ, 9'($urandom), 7'($urandom), 5'($urandom), 6'($urandom),
                  5'($urandom), 14'(idx));
    items_sent++;
  endtask

  // A write outside the frame is dropped by the block and does not count as an item.
  task automatic put_stray_pixel();
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    pick_color(r, g, b);
    offer_request(REQ_WRITE, 9'($urandom_range(511, FRAME_WIDTH)), 7'($urandom), r, g, b,
                  14'($urandom));
  endtask

  // The well-formed sequence: all four slots of one byte in a shuffled order, then a read
  // of that byte straight behind the last write.
  task automatic fill_and_read(input int byte_idx);
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    int         flip;
    flip = $urandom_range(3);
    for (int i = 0; i < 4; i++) begin
      pick_color(r, g, b);
      put_pixel(byte_idx, i ^ flip, r, g, b);
    end
    put_read(byte_idx);
  endtask

  // Random traffic until the given number of items has gone in.
  task automatic run_mix(input int count);
    int         goal;
    int         pick;
    int         target;
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
    goal = items_sent + count;
    while (items_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 45 || full_bytes.size() == 0) begin
        fill_and_read($urandom_range(STORE_BYTES - 1));
      end else if (pick < 70) begin
        put_read(full_bytes[$urandom_range(full_bytes.size() - 1)]);
      end else if (pick < 85) begin
        // Half of the lone writes repaint a complete byte, the rest land anywhere.
        if ($urandom_range(1)) begin
          target = full_bytes[$urandom_range(full_bytes.size() - 1)];
        end else begin
          target = $urandom_range(STORE_BYTES - 1);
        end
        pick_color(r, g, b);
        put_pixel(target, $urandom_range(3), r, g, b);
      end else if (pick < 93) begin
        put_read($urandom_range(INDEX_TOP, STORE_BYTES));
      end else begin
        put_stray_pixel();
      end
    end
  endtask

  // Stops offering and waits until every read has been answered, then lets the last
  // writes run out of the pipeline.
  task automatic settle();
    in_valid = 1'b0;
    while (bytes_due_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [1:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Loads all four color codes while the block is idle. A write to an index past the
  // register list rides along and must change nothing.
  task automatic apply_codes(input logic [1:0] black, input logic [1:0] white,
                             input logic [1:0] yellow, input logic [1:0] redc);
    settle();
    set_register(CFG_CODE_RED, redc);
    set_register(CFG_INDEX_W'($urandom_range((1 << CFG_INDEX_W) - 1, CFG_CODE_RED + 1)),
                 2'($urandom));
    set_register(CFG_CODE_YELLOW, yellow);
    set_register(CFG_CODE_WHITE, white);
    set_register(CFG_CODE_BLACK, black);
    cfg_valid = 1'b0;
  endtask

  // The receiver decides out_ready on every falling edge. When a long hold-off is asked
  // for, it keeps out_ready low for the stretch set by LONG_HOLD_CYCLES, whatever the sender does.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_done != hold_asks) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        hold_done++;
      end
      out_ready = ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog: a run that has not finished by now is hung.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("rgb565_epd_rotate_pack_tb: FAIL");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    req_type   = REQ_WRITE;
    column     = '0;
    row        = '0;
    red        = '0;
    green      = '0;
    blue       = '0;
    read_index = '0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_CODE_BLACK;
    cfg_data   = '0;
    gap_pct    = 0;
    stall_pct  = 0;
    hold_asks  = 0;
    hold_done  = 0;
    items_sent = 0;
    foreach (lanes_written[i]) lanes_written[i] = 4'h0;

    repeat (8) @(negedge clk);
    rst = 1'b0;

    // Directed part, with the codes as they come out of reset. The first byte of the
    // store (column 0, rows 127 down to 124) gets one pixel just inside each color.
    put_pixel(0, 0, 5'd21, 6'd11, 5'd11);
    put_pixel(0, 1, 5'd21, 6'd41, 5'd7);
    put_pixel(0, 2, 5'd7, 6'd9, 5'd7);
    put_pixel(0, 3, 5'd31, 6'd63, 5'd31);
    put_read(0);
    // The last byte (column 295, rows 3 down to 0) gets pixels just outside the colors,
    // which all fall to white, and a pure black.
    put_pixel(STORE_BYTES - 1, 0, 5'd20, 6'd0, 5'd0);
    put_pixel(STORE_BYTES - 1, 1, 5'd21, 6'd12, 5'd0);
    put_pixel(STORE_BYTES - 1, 2, 5'd8, 6'd0, 5'd0);
    put_pixel(STORE_BYTES - 1, 3, 5'd0, 6'd0, 5'd0);
    put_read(STORE_BYTES - 1);
    // Repainting one slot must leave its three neighbors alone.
    put_pixel(0, 2, 5'd31, 6'd0, 5'd0);
    put_read(0);
    // Writes past the right edge of the frame are dropped.
    offer_request(REQ_WRITE, 9'(FRAME_WIDTH), 7'd0, 5'd0, 6'd0, 5'd0, 14'(INDEX_TOP));
    offer_request(REQ_WRITE, 9'd511, 7'd127, 5'd31, 6'd0, 5'd0, 14'd0);
    put_read(STORE_BYTES - 1);
    // Reads past the end of the store come back as zero.
    put_read(STORE_BYTES);
    put_read(INDEX_TOP);

    // Reversed codes, no idling on either side. Early on the receiver holds off for a
    // long stretch while requests keep coming, so the result queue fills and in_ready drops.
    apply_codes(2'd3, 2'd2, 2'd1, 2'd0);
    gap_pct   = 0;
    stall_pct = 0;
    hold_asks++;
    run_mix(130);

    // Every color mapped to zero, sender idling about half the time.
    apply_codes(2'd0, 2'd0, 2'd0, 2'd0);
    gap_pct   = 51;
    stall_pct = 0;
    run_mix(130);

    // Every color mapped to three, receiver stalling about half the time. Halfway through
    // the sender pauses until every read has been answered.
    apply_codes(2'd3, 2'd3, 2'd3, 2'd3);
    gap_pct   = 0;
    stall_pct = 51;
    run_mix(65);
    settle();
    run_mix(65);

    // Random codes with light idling on both sides, and a second long hold-off.
    apply_codes(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
    gap_pct   = 20;
    stall_pct = 20;
    hold_asks++;
    run_mix(130);

    // Random codes again at full rate.
    apply_codes(2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom));
    gap_pct   = 0;
    stall_pct = 0;
    run_mix(130);

    settle();
    if (mismatches == 0) begin
      $display("rgb565_epd_rotate_pack_tb: PASS");
    end else begin
      $display("rgb565_epd_rotate_pack_tb: FAIL");
    end
    $finish;
  end

endmodule
